FILE: src/transform_record_quantizer_core_defines.svh
// assertion helpers for the quantizer core
`ifndef TRANSFORM_RECORD_QUANTIZER_CORE_DEFINES_SVH
`define TRANSFORM_RECORD_QUANTIZER_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TRQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quantizer core check failed");

// next-cycle implication
`define TRQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quantizer core check failed");

`endif

FILE: src/trq_pkg.sv
package trq_pkg;

    localparam int DIV_STAGES = 3;
    // stage 0 unpack, divider stages, then round/clamp, multiply, round, align, final round
    localparam int LANE_LAT   = 1 + DIV_STAGES + 5;
    localparam int NUM_LANES  = 6;

    localparam logic [23:0]        ROT_DIV_MANT  = 24'hCCCCCD;
    localparam logic signed [9:0]  ROT_DIV_EXP   = 10'sd1;
    localparam logic [23:0]        SCL_DIV_MANT  = 24'h800000;
    localparam logic signed [9:0]  SCL_DIV_EXP   = 10'sd4;
    // floor(2^49 / divisor mantissa)
    localparam logic [26:0]        ROT_DIV_RECIP = 27'h27FFFFF;
    localparam logic [26:0]        SCL_DIV_RECIP = 27'h4000000;
    localparam logic [15:0]        ROT_FULL      = 16'd32767;
    localparam logic [15:0]        SCL_FULL      = 16'd65535;
    localparam logic [23:0]        MANT_ONE      = 24'h800000;
    // below this biased exponent the quantized result is always zero
    localparam logic [7:0]         EXP_MIN_FIELD = 8'd100;

    typedef enum logic {
        MODE_SCALE,
        MODE_ROT
    } t_mode;

    typedef struct packed {
        logic              sgn;
        logic              zero;
        logic signed [9:0] expo;
    } t_side;

    function automatic logic [31:0] sanitize(input logic [31:0] w);
        logic [31:0] r;
        r = (w[30:23] == 8'hFF) ? 32'h0000_0000 : w;
        return r;
    endfunction

endpackage

FILE: src/transform_record_quantizer_core.sv
// Transform record quantizer. One item (id, position, rotation, scale) is taken at every
// clock edge where start is high; busy is always low, so items may be issued back to back,
// one per cycle. Each result appears on the o_ ports for one cycle with o_valid high,
// after its item has passed the pipeline: six quantizer lanes run side by side, each
// with an unpack stage, a three-stage reciprocal divider (estimate, multiply back,
// correct) and five rounding, scaling and alignment stages, followed by one merge
// register. The receiver cannot stall, so every result must be captured in the cycle it
// is shown.
`include "transform_record_quantizer_core_defines.svh"

module transform_record_quantizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_entity_id,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_rot_x,
    input  logic [31:0] i_rot_y,
    input  logic [31:0] i_rot_z,
    input  logic [31:0] i_scale_x,
    input  logic [31:0] i_scale_y,
    input  logic [31:0] i_scale_z,
    output logic        o_valid,
    output logic [31:0] o_out_id,
    output logic [31:0] o_clean_pos_x,
    output logic [31:0] o_clean_pos_y,
    output logic [31:0] o_clean_pos_z,
    output logic signed [15:0] o_quant_rot_x,
    output logic signed [15:0] o_quant_rot_y,
    output logic signed [15:0] o_quant_rot_z,
    output logic [15:0] o_quant_scale_x,
    output logic [15:0] o_quant_scale_y,
    output logic [15:0] o_quant_scale_z
);

    assign busy = 1'b0;

    logic [31:0] lane_in  [trq_pkg::NUM_LANES];
    logic [15:0] lane_out [trq_pkg::NUM_LANES];

    assign lane_in[0] = i_rot_x;
    assign lane_in[1] = i_rot_y;
    assign lane_in[2] = i_rot_z;
    assign lane_in[3] = i_scale_x;
    assign lane_in[4] = i_scale_y;
    assign lane_in[5] = i_scale_z;

    for (genvar k = 0; k < trq_pkg::NUM_LANES; k++) begin : g_lane
        trq_lane u_lane (
            .i_clk   (i_clk),
            .i_mode  ((k < 3) ? trq_pkg::MODE_ROT : trq_pkg::MODE_SCALE),
            .i_value (lane_in[k]),
            .o_quant (lane_out[k])
        );
    end

    // id and sanitized position ride alongside the lanes
    logic [trq_pkg::LANE_LAT-1:0] r_vld;
    logic [127:0]                 r_pass [trq_pkg::LANE_LAT];
    logic [127:0]                 n_pass;

    assign n_pass = {i_entity_id, trq_pkg::sanitize(i_pos_x),
                     trq_pkg::sanitize(i_pos_y), trq_pkg::sanitize(i_pos_z)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[trq_pkg::LANE_LAT-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass[0] <= n_pass;
        for (int i = 1; i < trq_pkg::LANE_LAT; i++) begin
            r_pass[i] <= r_pass[i-1];
        end
    end

    // merge stage
    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[trq_pkg::LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_id        <= r_pass[trq_pkg::LANE_LAT-1][127:96];
        o_clean_pos_x   <= r_pass[trq_pkg::LANE_LAT-1][95:64];
        o_clean_pos_y   <= r_pass[trq_pkg::LANE_LAT-1][63:32];
        o_clean_pos_z   <= r_pass[trq_pkg::LANE_LAT-1][31:0];
        o_quant_rot_x   <= lane_out[0];
        o_quant_rot_y   <= lane_out[1];
        o_quant_rot_z   <= lane_out[2];
        o_quant_scale_x <= lane_out[3];
        o_quant_scale_y <= lane_out[4];
        o_quant_scale_z <= lane_out[5];
    end

    assign o_valid = r_valid;

    `TRQ_ASSERT_NEXT(a_merge_follows, r_vld[trq_pkg::LANE_LAT-1], o_valid)
    `TRQ_ASSERT_IMPL(a_pos_finite, o_valid, o_clean_pos_x[30:23] != 8'hFF && o_clean_pos_y[30:23] != 8'hFF && o_clean_pos_z[30:23] != 8'hFF)
    `TRQ_ASSERT_IMPL(a_rot_range, o_valid, o_quant_rot_x != 16'h8000 && o_quant_rot_y != 16'h8000 && o_quant_rot_z != 16'h8000)

endmodule

FILE: src/trq_div.sv
module trq_div (
    input  logic           i_clk,
    input  logic [23:0]    i_mant,
    input  logic [23:0]    i_divisor,
    input  logic [26:0]    i_recip,
    input  trq_pkg::t_side i_side,
    output logic [25:0]    o_quo,
    output logic           o_rem_nz,
    output trq_pkg::t_side o_side
);

    // stage 1: quotient estimate by reciprocal, never high and at most one low
    logic [50:0]    r_est;
    logic [23:0]    r_mant1;
    trq_pkg::t_side r_side1;

    always_ff @(posedge i_clk) begin
        r_est   <= i_mant * i_recip;
        r_mant1 <= i_mant;
        r_side1 <= i_side;
    end

    // stage 2: multiply the estimate back
    logic [25:0]    q0;
    logic [49:0]    r_back;
    logic [25:0]    r_q0;
    logic [23:0]    r_mant2;
    trq_pkg::t_side r_side2;

    assign q0 = r_est[49:24];

    always_ff @(posedge i_clk) begin
        r_back  <= q0 * i_divisor;
        r_q0    <= q0;
        r_mant2 <= r_mant1;
        r_side2 <= r_side1;
    end

    // stage 3: remainder, one correction step
    logic [49:0]    rem3;
    logic           ge3;
    logic [49:0]    rem_fix;
    logic [25:0]    r_quo;
    logic           r_rem_nz;
    trq_pkg::t_side r_side3;

    always_comb begin
        rem3    = {1'b0, r_mant2, 25'd0} - r_back;
        ge3     = (rem3 >= {26'd0, i_divisor});
        rem_fix = ge3 ? (rem3 - {26'd0, i_divisor}) : rem3;
    end

    always_ff @(posedge i_clk) begin
        r_quo    <= r_q0 + {25'd0, ge3};
        r_rem_nz <= |rem_fix;
        r_side3  <= r_side2;
    end

    assign o_quo    = r_quo;
    assign o_rem_nz = r_rem_nz;
    assign o_side   = r_side3;

endmodule

FILE: src/trq_lane.sv
module trq_lane (
    input  logic           i_clk,
    input  trq_pkg::t_mode i_mode,
    input  logic [31:0]    i_value,
    output logic [15:0]    o_quant
);

    logic [23:0]       divisor;
    logic [26:0]       recip;
    logic signed [9:0] div_exp;
    logic [15:0]       full;

    assign divisor = (i_mode == trq_pkg::MODE_ROT) ? trq_pkg::ROT_DIV_MANT
                                                   : trq_pkg::SCL_DIV_MANT;
    assign recip   = (i_mode == trq_pkg::MODE_ROT) ? trq_pkg::ROT_DIV_RECIP
                                                   : trq_pkg::SCL_DIV_RECIP;
    assign div_exp = (i_mode == trq_pkg::MODE_ROT) ? trq_pkg::ROT_DIV_EXP
                                                   : trq_pkg::SCL_DIV_EXP;
    assign full    = (i_mode == trq_pkg::MODE_ROT) ? trq_pkg::ROT_FULL
                                                   : trq_pkg::SCL_FULL;

    // stage 0: unpack
    logic [31:0]    san;
    logic [23:0]    n_mant0;
    trq_pkg::t_side n_side0;
    logic [23:0]    r_mant0;
    trq_pkg::t_side r_side0;

    always_comb begin
        san          = trq_pkg::sanitize(i_value);
        n_mant0      = {1'b1, san[22:0]};
        n_side0.sgn  = san[31];
        n_side0.zero = (san[30:23] < trq_pkg::EXP_MIN_FIELD);
        n_side0.expo = $signed({2'b00, san[30:23]}) - 10'sd127;
    end

    always_ff @(posedge i_clk) begin
        r_mant0 <= n_mant0;
        r_side0 <= n_side0;
    end

    logic [25:0]    quo;
    logic           rem_nz;
    trq_pkg::t_side dside;

    trq_div u_div (
        .i_clk     (i_clk),
        .i_mant    (r_mant0),
        .i_divisor (divisor),
        .i_recip   (recip),
        .i_side    (r_side0),
        .o_quo     (quo),
        .o_rem_nz  (rem_nz),
        .o_side    (dside)
    );

    // stage A: round quotient, clamp magnitude to one
    logic              hi_a;
    logic [23:0]       m24_a;
    logic              rb_a;
    logic              st_a;
    logic [24:0]       sum_a;
    logic signed [9:0] ex_a;
    logic [23:0]       n_mn;
    logic signed [9:0] n_en;
    logic              n_zero_a;
    logic [23:0]       r_mn;
    logic signed [9:0] r_en;
    logic              r_sgn_a;
    logic              r_zero_a;

    always_comb begin
        hi_a  = quo[25];
        m24_a = hi_a ? quo[25:2] : quo[24:1];
        rb_a  = hi_a ? quo[1] : quo[0];
        st_a  = hi_a ? (quo[0] | rem_nz) : rem_nz;
        ex_a  = dside.expo - div_exp - (hi_a ? 10'sd0 : 10'sd1);
        sum_a = {1'b0, m24_a} + {24'd0, rb_a & (st_a | m24_a[0])};
        if (sum_a[24]) begin
            n_mn = trq_pkg::MANT_ONE;
            n_en = ex_a + 10'sd1;
        end else begin
            n_mn = sum_a[23:0];
            n_en = ex_a;
        end
        if (n_en > 10'sd0 || (n_en == 10'sd0 && n_mn != trq_pkg::MANT_ONE)) begin
            n_mn = trq_pkg::MANT_ONE;
            n_en = 10'sd0;
        end
        n_zero_a = dside.zero | ((i_mode == trq_pkg::MODE_SCALE) & dside.sgn);
    end

    always_ff @(posedge i_clk) begin
        r_mn     <= n_mn;
        r_en     <= n_en;
        r_sgn_a  <= dside.sgn;
        r_zero_a <= n_zero_a;
    end

    // stage B: scale by full-range constant
    logic [39:0]       r_prod;
    logic signed [9:0] r_en_b;
    logic              r_sgn_b;
    logic              r_zero_b;

    always_ff @(posedge i_clk) begin
        r_prod   <= r_mn * full;
        r_en_b   <= r_en;
        r_sgn_b  <= r_sgn_a;
        r_zero_b <= r_zero_a;
    end

    // stage C: round product to single precision
    logic [5:0]        lead_c;
    logic [4:0]        sa_c;
    logic [39:0]       shf_c;
    logic [39:0]       stm_c;
    logic              rb_c;
    logic              st_c;
    logic [24:0]       sum_c;
    logic [23:0]       n_mq;
    logic signed [9:0] n_eq;
    logic [23:0]       r_mq;
    logic signed [9:0] r_eq;
    logic              r_sgn_c;
    logic              r_zero_c;

    always_comb begin
        if (r_prod[39]) begin
            lead_c = 6'd39;
        end else if (r_prod[38]) begin
            lead_c = 6'd38;
        end else begin
            lead_c = 6'd37;
        end
        sa_c  = 5'(lead_c - 6'd23);
        shf_c = r_prod >> sa_c;
        rb_c  = r_prod[sa_c - 5'd1];
        stm_c = (40'd1 << (sa_c - 5'd1)) - 40'd1;
        st_c  = |(r_prod & stm_c);
        sum_c = {1'b0, shf_c[23:0]} + {24'd0, rb_c & (st_c | shf_c[0])};
        n_eq  = r_en_b + $signed({4'd0, lead_c}) - 10'sd46;
        if (sum_c[24]) begin
            n_mq = trq_pkg::MANT_ONE;
            n_eq = n_eq + 10'sd1;
        end else begin
            n_mq = sum_c[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mq     <= n_mq;
        r_eq     <= n_eq;
        r_sgn_c  <= r_sgn_b;
        r_zero_c <= r_zero_b;
    end

    // stage D: fixed point with 26 fraction bits, add one half
    logic signed [10:0] sh_d;
    logic [10:0]        rs_d;
    logic [55:0]        wide_d;
    logic [45:0]        qfix_d;
    logic               n_stk;
    logic [45:0]        r_sum;
    logic               r_stk;
    logic               r_sgn_d;
    logic               r_zero_d;

    always_comb begin
        sh_d   = 11'(r_eq) + 11'sd26;
        rs_d   = 11'(-sh_d);
        wide_d = '0;
        if (sh_d >= 11'sd0) begin
            qfix_d = {22'd0, r_mq} << sh_d[4:0];
            n_stk  = 1'b0;
        end else if (rs_d > 11'd31) begin
            qfix_d = '0;
            n_stk  = 1'b1;
        end else begin
            wide_d = {r_mq, 32'd0} >> rs_d[4:0];
            qfix_d = {22'd0, wide_d[55:32]};
            n_stk  = |wide_d[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= qfix_d + (46'd1 << 25);
        r_stk    <= n_stk;
        r_sgn_d  <= r_sgn_c;
        r_zero_d <= r_zero_c;
    end

    // stage E: round the sum to single precision, truncate, apply sign
    logic [5:0]  p_e;
    logic [5:0]  u_e;
    logic [45:0] low_e;
    logic [45:0] keep_e;
    logic        inc_e;
    logic [45:0] rnd_e;
    logic [15:0] mag_e;
    logic [15:0] n_quant;
    logic [15:0] r_quant;

    always_comb begin
        p_e = 6'd25;
        for (int i = 25; i < 46; i++) begin
            if (r_sum[i]) begin
                p_e = 6'(i);
            end
        end
        u_e    = p_e - 6'd23;
        low_e  = (46'd1 << u_e) - 46'd1;
        keep_e = r_sum & ~low_e;
        inc_e  = r_sum[u_e - 6'd1] & ((|(r_sum & (low_e >> 1))) | r_stk | r_sum[u_e]);
        rnd_e  = keep_e + (inc_e ? (46'd1 << u_e) : 46'd0);
        mag_e  = rnd_e[41:26];
        if (r_zero_d) begin
            n_quant = '0;
        end else if (i_mode == trq_pkg::MODE_ROT && r_sgn_d) begin
            n_quant = 16'd0 - mag_e;
        end else begin
            n_quant = mag_e;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quant <= n_quant;
    end

    assign o_quant = r_quant;

endmodule

FILE: tb/trq_record_checker.sv
`timescale 1ns / 1ps

module trq_record_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        i_entity_id,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic [31:0]        i_rot_x,
    input  logic [31:0]        i_rot_y,
    input  logic [31:0]        i_rot_z,
    input  logic [31:0]        i_scale_x,
    input  logic [31:0]        i_scale_y,
    input  logic [31:0]        i_scale_z,
    input  logic               o_valid,
    input  logic [31:0]        o_out_id,
    input  logic [31:0]        o_clean_pos_x,
    input  logic [31:0]        o_clean_pos_y,
    input  logic [31:0]        o_clean_pos_z,
    input  logic signed [15:0] o_quant_rot_x,
    input  logic signed [15:0] o_quant_rot_y,
    input  logic signed [15:0] o_quant_rot_z,
    input  logic [15:0]        o_quant_scale_x,
    input  logic [15:0]        o_quant_scale_y,
    input  logic [15:0]        o_quant_scale_z,
    output int                 o_fail_cnt,
    output int                 o_pending
);

    typedef struct {
        logic [31:0]        id;
        logic [31:0]        pos [3];
        logic signed [15:0] rot [3];
        logic [15:0]        scl [3];
    } t_quant_rec;

    t_quant_rec record_q [$];

    // bits of a finite single to an exact real
    function automatic real single_to_real(input logic [31:0] w);
        real v;
        logic [10:0] de;
        if (w[30:23] == 8'd0) begin
            v = real'(w[22:0]) * 2.0 ** (-149);
        end else begin
            de = 11'(w[30:23]) + 11'd896;
            v = $bitstoreal({1'b0, de, w[22:0], 29'b0});
        end
        return w[31] ? -v : v;
    endfunction

    // round a real to single precision, nearest even; double rounding is harmless here
    function automatic real round_single(input real x);
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        real         v;
        d = $realtobits(x);
        if (d[62:0] == 63'd0) return 0.0;
        e  = int'(d[62:52]) - 1023;
        m  = {11'b0, 1'b1, d[51:0]};
        sh = 29 + ((e < -126) ? (-126 - e) : 0);
        if (sh > 60) return 0.0;
        kept = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
        v = real'(kept) * 2.0 ** (e - 52 + sh);
        return d[63] ? -v : v;
    endfunction

    function automatic logic [31:0] clean_bits(input logic [31:0] w);
        return (w[30:23] == 8'hFF) ? 32'd0 : w;
    endfunction

    function automatic logic signed [15:0] quant_rotation(input logic [31:0] w);
        real n;
        real q;
        real r;
        int  i;
        n = round_single(single_to_real(clean_bits(w)) / single_to_real(32'h404CCCCD));
        if (n > 1.0) n = 1.0;
        if (n < -1.0) n = -1.0;
        q = round_single(n * 32767.0);
        r = (q >= 0.0) ? round_single(q + 0.5) : round_single(q - 0.5);
        i = $rtoi(r);
        return i[15:0];
    endfunction

    function automatic logic [15:0] quant_scale(input logic [31:0] w);
        real n;
        real q;
        real r;
        int  i;
        n = round_single(single_to_real(clean_bits(w)) / 16.0);
        if (n > 1.0) n = 1.0;
        if (n < 0.0) n = 0.0;
        q = round_single(n * 65535.0);
        r = round_single(q + 0.5);
        i = $rtoi(r);
        return i[15:0];
    endfunction

    assign o_pending = record_q.size();

    always @(posedge i_clk) begin
        t_quant_rec exp_rec;
        t_quant_rec got;
        int         errs;
        errs = 0;
        if (i_rst_n && start && !busy) begin
            exp_rec.id     = i_entity_id;
            exp_rec.pos[0] = clean_bits(i_pos_x);
            exp_rec.pos[1] = clean_bits(i_pos_y);
            exp_rec.pos[2] = clean_bits(i_pos_z);
            exp_rec.rot[0] = quant_rotation(i_rot_x);
            exp_rec.rot[1] = quant_rotation(i_rot_y);
            exp_rec.rot[2] = quant_rotation(i_rot_z);
            exp_rec.scl[0] = quant_scale(i_scale_x);
            exp_rec.scl[1] = quant_scale(i_scale_y);
            exp_rec.scl[2] = quant_scale(i_scale_z);
            record_q.insert(record_q.size(), exp_rec);
        end
        if (i_rst_n && o_valid) begin
            got.id  = o_out_id;
            got.pos = '{o_clean_pos_x, o_clean_pos_y, o_clean_pos_z};
            got.rot = '{o_quant_rot_x, o_quant_rot_y, o_quant_rot_z};
            got.scl = '{o_quant_scale_x, o_quant_scale_y, o_quant_scale_z};
            if (record_q.size() == 0) begin
                $error("result with no item outstanding, id %h", got.id);
                errs++;
            end else begin
                exp_rec = record_q.pop_front();
                if (got.id !== exp_rec.id) begin
                    $error("out_id: expected %h, got %h", exp_rec.id, got.id);
                    errs++;
                end
                for (int k = 0; k < 3; k++) begin
                    if (got.pos[k] !== exp_rec.pos[k]) begin
                        $error("clean_pos[%0d]: expected %h, got %h", k, exp_rec.pos[k],
                               got.pos[k]);
                        errs++;
                    end
                    if (got.rot[k] !== exp_rec.rot[k]) begin
                        $error("quant_rot[%0d]: expected %0d, got %0d", k, exp_rec.rot[k],
                               got.rot[k]);
                        errs++;
                    end
                    if (got.scl[k] !== exp_rec.scl[k]) begin
                        $error("quant_scale[%0d]: expected %0d, got %0d", k, exp_rec.scl[k],
                               got.scl[k]);
                        errs++;
                    end
                end
            end
        end
        if (errs != 0) begin
            o_fail_cnt <= o_fail_cnt + errs;
        end
    end

endmodule

FILE: tb/tb_transform_record_quantizer_core.sv
`timescale 1ns / 1ps

module tb_transform_record_quantizer_core;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_entity_id;
    logic [31:0]        i_pos_x, i_pos_y, i_pos_z;
    logic [31:0]        i_rot_x, i_rot_y, i_rot_z;
    logic [31:0]        i_scale_x, i_scale_y, i_scale_z;
    logic               o_valid;
    logic [31:0]        o_out_id;
    logic [31:0]        o_clean_pos_x, o_clean_pos_y, o_clean_pos_z;
    logic signed [15:0] o_quant_rot_x, o_quant_rot_y, o_quant_rot_z;
    logic [15:0]        o_quant_scale_x, o_quant_scale_y, o_quant_scale_z;
    int                 fail_cnt;
    int                 pending;
    int                 n_sent;

    transform_record_quantizer_core u_dut (.*);

    trq_record_checker u_chk (.*, .o_fail_cnt(fail_cnt), .o_pending(pending));

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // random single: specials, subnormals, full noise, or an exponent band around the range
    function automatic logic [31:0] rand_single(input int lo_e, input int hi_e);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return {1'($urandom), 8'hFF, 23'($urandom)};
        else if (sel < 14)
            return {1'($urandom), 31'd0};
        else if (sel < 20)
            return {1'($urandom), 8'd0, 23'($urandom)};
        else if (sel < 35)
            return $urandom;
        return {1'($urandom), 8'($urandom_range(lo_e, hi_e)), 23'($urandom)};
    endfunction

    task automatic send_record(input logic [31:0] id, input logic [31:0] p[3],
                               input logic [31:0] r[3], input logic [31:0] s[3]);
        i_entity_id <= id;
        i_pos_x   <= p[0];
        i_pos_y   <= p[1];
        i_pos_z   <= p[2];
        i_rot_x   <= r[0];
        i_rot_y   <= r[1];
        i_rot_z   <= r[2];
        i_scale_x <= s[0];
        i_scale_y <= s[1];
        i_scale_z <= s[2];
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        #100000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [31:0] p[3];
        logic [31:0] r[3];
        logic [31:0] s[3];
        logic [31:0] edge_vals[12];
        n_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        {i_entity_id, i_pos_x, i_pos_y, i_pos_z} = '0;
        {i_rot_x, i_rot_y, i_rot_z, i_scale_x, i_scale_y, i_scale_z} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nan, infinities, signed zero, subnormals, range ends, saturation
        edge_vals = '{32'h7FC00000, 32'hFF800001, 32'h7F800000, 32'hFF800000,
                      32'h80000000, 32'h00000001, 32'h807FFFFF, 32'h404CCCCD,
                      32'hC04CCCCD, 32'h41800000, 32'h7F7FFFFF, 32'hFF7FFFFF};
        foreach (edge_vals[i]) begin
            p = '{edge_vals[i], edge_vals[(i + 1) % 12], edge_vals[(i + 5) % 12]};
            r = '{edge_vals[i], edge_vals[(i + 3) % 12], edge_vals[(i + 7) % 12]};
            s = '{edge_vals[i], edge_vals[(i + 2) % 12], edge_vals[(i + 9) % 12]};
            send_record((i % 2) ? 32'hFFFFFFFF : 32'h0, p, r, s);
        end
        // mid-range values, small magnitudes, one lsb of the full scale
        p = '{32'h3F800000, 32'hBF800000, 32'h00800000};
        r = '{32'h3FCCCCCD, 32'hBFCCCCCD, 32'h3A4CCCCD};
        s = '{32'h41000000, 32'h3F800000, 32'hBF800000};
        send_record(32'h12345678, p, r, s);
        r = '{32'h404CCCCE, 32'h38D1B717, 32'hB8D1B717};
        s = '{32'h41800001, 32'h3A800000, 32'h39800000};
        send_record(32'hA5A5A5A5, p, r, s);

        for (int n = 0; n < 450; n++) begin
            if (n == 300) begin
                idle_cycle();
                while (pending != 0) @(posedge i_clk);
            end
            while ((n < 150 || n > 250) && $urandom_range(0, 99) < 27) idle_cycle();
            for (int k = 0; k < 3; k++) begin
                p[k] = rand_single(0, 254);
                r[k] = rand_single(112, 131);
                s[k] = rand_single(112, 133);
            end
            send_record($urandom, p, r, s);
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d records through the quantizer: nan, infinity, signed zero,", n_sent);
        $display("subnormal, saturating and in-range fields, with and without input gaps");
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
